FILE: hdl/hrhp_pkg.sv
package hrhp_pkg;

  // input kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // result roles
  localparam logic [1:0] ROLE_METHOD = 2'd0;
  localparam logic [1:0] ROLE_PATH   = 2'd1;
  localparam logic [1:0] ROLE_QUERY  = 2'd2;
  localparam logic [1:0] ROLE_STATUS = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DISCON = 2'd1;
  localparam logic [1:0] ST_BADREQ = 2'd2;

  // token phase on the request line
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_METHOD = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_PATH   = 3'd3;
  localparam logic [2:0] PH_QUERY  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int KA_LEN = 22;
  localparam int MI_W   = $clog2(KA_LEN + 1);
  localparam logic [7:0] KA_TEXT [KA_LEN] = '{
    "C", "o", "n", "n", "e", "c", "t", "i", "o", "n", ":", " ",
    "k", "e", "e", "p", "-", "a", "l", "i", "v", "e"
  };

  // output queue
  localparam int QDEPTH = 4;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic            first_line;
    logic            line_has_bytes;
    logic            cr_pending;
    logic            nul_seen;
    logic [2:0]      token_phase;
    logic [MI_W-1:0] match_index;
    logic            header_mismatch;
    logic            keep_alive_seen;
    logic            bad_request_seen;
    logic            finished;
  } st_t;

  typedef struct packed {
    logic [1:0] role;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       keep_alive;
    logic       last;
  } res_t;

  // up to two results per request
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  typedef struct packed {
    st_t        st;
    logic       put;
    logic [1:0] role;
    logic [7:0] b;
  } lb_t;

  function automatic st_t st_reset();
    st_t s;
    s            = '0;
    s.first_line = 1'b1;
    return s;
  endfunction

  // one ordinary line byte
  function automatic lb_t line_byte(st_t s_in, logic [7:0] b);
    lb_t r;
    r      = '0;
    r.st   = s_in;
    r.b    = b;
    r.st.line_has_bytes = 1'b1;
    if (!s_in.nul_seen) begin
      if (b == CH_NUL) begin
        r.st.nul_seen = 1'b1;
      end else if (s_in.first_line) begin
        case (s_in.token_phase)
          PH_LEAD: begin
            if (b != CH_SPACE) begin
              r.st.token_phase = PH_METHOD;
              r.put            = 1'b1;
              r.role           = ROLE_METHOD;
            end
          end
          PH_METHOD: begin
            if (b == CH_SPACE) begin
              r.st.token_phase = PH_GAP;
            end else begin
              r.put  = 1'b1;
              r.role = ROLE_METHOD;
            end
          end
          PH_GAP: begin
            if (b == CH_QMARK) begin
              r.st.token_phase = PH_QUERY;
            end else if (b != CH_SPACE) begin
              r.st.token_phase = PH_PATH;
              r.put            = 1'b1;
              r.role           = ROLE_PATH;
            end
          end
          PH_PATH: begin
            if (b == CH_SPACE) begin
              r.st.token_phase = PH_DONE;
            end else if (b == CH_QMARK) begin
              r.st.token_phase = PH_QUERY;
            end else begin
              r.put  = 1'b1;
              r.role = ROLE_PATH;
            end
          end
          PH_QUERY: begin
            if (b == CH_SPACE) begin
              r.st.token_phase = PH_DONE;
            end else begin
              r.put  = 1'b1;
              r.role = ROLE_QUERY;
            end
          end
          default: ;
        endcase
      end else begin
        if ((s_in.match_index < MI_W'(KA_LEN)) && (b == KA_TEXT[s_in.match_index])) begin
          r.st.match_index = s_in.match_index + MI_W'(1);
        end else begin
          r.st.header_mismatch = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/hrhp_core.sv
module hrhp_core
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  output push_t      push
);

  st_t st_r, st_nxt;

  always_comb begin
    lb_t        r1;
    lb_t        r2;
    res_t       ra;
    res_t       rb;
    res_t       rs;
    logic       has_st;
    r1     = '0;
    r2     = '0;
    ra     = '0;
    rb     = '0;
    rs     = '0;
    has_st = 1'b0;
    st_nxt = st_r;
    if (kind == KIND_START) begin
      st_nxt = st_reset();
    end else if (kind == KIND_BYTE || kind == KIND_CLOSE) begin
      if (!st_r.finished) begin
        if (kind == KIND_CLOSE) begin
          st_nxt.cr_pending = 1'b0;
          has_st            = 1'b1;
          rs.status         = st_r.bad_request_seen ? ST_BADREQ : ST_DISCON;
        end else if (data_byte == CH_LF) begin
          st_nxt.cr_pending = 1'b0;
          if (!st_r.line_has_bytes) begin
            has_st    = 1'b1;
            rs.status = st_r.bad_request_seen ? ST_BADREQ : ST_OK;
          end else if (st_r.first_line) begin
            if (st_r.token_phase < PH_PATH) st_nxt.bad_request_seen = 1'b1;
          end else if (!st_r.header_mismatch && st_r.match_index == MI_W'(KA_LEN)) begin
            st_nxt.keep_alive_seen = 1'b1;
          end
          st_nxt.first_line      = 1'b0;
          st_nxt.line_has_bytes  = 1'b0;
          st_nxt.nul_seen        = 1'b0;
          st_nxt.match_index     = '0;
          st_nxt.header_mismatch = 1'b0;
        end else begin
          // a held CR not followed by LF is an ordinary byte
          if (st_r.cr_pending) begin
            st_nxt.cr_pending = 1'b0;
            r1     = line_byte(st_nxt, CH_CR);
            st_nxt = r1.st;
          end
          if (data_byte == CH_CR) begin
            st_nxt.cr_pending = 1'b1;
          end else begin
            r2     = line_byte(st_nxt, data_byte);
            st_nxt = r2.st;
          end
        end
        if (has_st) begin
          rs.role            = ROLE_STATUS;
          rs.keep_alive      = st_r.keep_alive_seen;
          st_nxt.finished    = 1'b1;
        end
      end
    end

    ra.role     = r1.role;
    ra.out_byte = r1.b;
    rb.role     = r2.role;
    rb.out_byte = r2.b;
    push = '0;
    if (has_st) begin
      push.n      = 2'd1;
      push.a      = rs;
      push.a.last = 1'b1;
    end else if (r1.put && r2.put) begin
      push.n      = 2'd2;
      push.a      = ra;
      push.b      = rb;
      push.b.last = 1'b1;
    end else if (r1.put) begin
      push.n      = 2'd1;
      push.a      = ra;
      push.a.last = 1'b1;
    end else if (r2.put) begin
      push.n      = 2'd1;
      push.a      = rb;
      push.a.last = 1'b1;
    end
    if (!fire) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_reset();
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_status_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && push.a.role == ROLE_STATUS) |=> st_r.finished)
    else $error("status sent but request not finished");
  a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.match_index <= MI_W'(KA_LEN))
    else $error("header match index out of range");
  a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && st_r.finished && kind != KIND_START) |-> push.n == 2'd0)
    else $error("result after finished request");
`endif

endmodule

FILE: hdl/hrhp_fifo.sv
module hrhp_fifo
  import hrhp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  output res_t  out_item,
  input  logic  out_ready
);

  res_t            q_mem [QDEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic            pop;

  assign out_valid = cnt_r != '0;
  assign out_item  = q_mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two results
  assign room      = cnt_r <= QC_W'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_mem[wr_ptr_r] <= push.a;
    if (push.n == 2'd2) q_mem[wr_ptr_r + QP_W'(1)] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QP_W'(push.n);
      if (pop) rd_ptr_r <= rd_ptr_r + QP_W'(1);
      cnt_r <= cnt_r + QC_W'(push.n) - QC_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QC_W'(QDEPTH))
    else $error("result queue overflow");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (cnt_r + QC_W'(push.n) <= QC_W'(QDEPTH)))
    else $error("push without room");
`endif

endmodule

FILE: hdl/http_request_head_parser.sv
// HTTP request head parser.
// Input channel (in_*): one request per cycle while in_tready is high; in_tuser
// is the kind (byte, start of a new request, peer close) and in_tdata the received byte.
// Output channel (out_*): method, path and query bytes of the request line
// as they arrive, then one end-of-request status (tuser = role). out_tlast
// marks the final result caused by one input request; a request may cause
// zero, one or two results (a held CR released as a line byte plus the
// new byte).
// Results are registered in the result queue before they reach the output.
// Throughput: one input request per cycle as long as the
// four-entry result queue has room for two more entries; a request that
// yields two results sends them to the output one after the other.
// Reset (rst_n low, synchronous): parser returns to the start of a request
// line and the result queue empties.
// When the receiver stalls, results wait in the queue and in_tready drops
// once fewer than two entries are free; nothing is lost.
module http_request_head_parser
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] status, [10] keep_alive
  output logic [1:0]  out_tuser,  // [1:0] role
  output logic        out_tlast
);

  logic  fire;
  logic  room;
  push_t push;
  res_t  head;

  assign in_tready = room;
  assign fire      = in_tvalid && in_tready;

  // per-request parse state and result generation
  hrhp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .kind      (in_tuser),
    .data_byte (in_tdata),
    .push      (push)
  );

  // result queue decouples the two sides
  hrhp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_item  (head),
    .out_ready (out_tready)
  );

  assign out_tdata = {5'd0, head.keep_alive, head.status, head.out_byte};
  assign out_tuser = head.role;
  assign out_tlast = head.last;

endmodule
